FILE: hw/rtl/bbss_pkg.sv
// ----------------------------------------------------------------------------
// bbss_pkg
// Shared types, constants and helpers of the binary blob size selector.
// ----------------------------------------------------------------------------
package bbss_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_OBJECTS = 4095;

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int AW   = XW + YW;
   localparam int SPW  = AW + 1;
   localparam int SZW  = 17;
   localparam int CNTW = 12;
   localparam int DIMW = 9;
   localparam int RATW = 16;

   localparam logic [SPW-1:0] AREA = SPW'(MAX_WIDTH * MAX_HEIGHT);

   // register indexes of the csr port
   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_EIGHT  = 3'd2,
      REG_OBJVAL = 3'd3,
      REG_RATIO  = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_POP,
      ST_POP_EV,
      ST_NB_RD,
      ST_NB_EV,
      ST_DONE
   } state_type;

   // effective frame settings seen by the fill core
   typedef struct packed {
      logic [DIMW-1:0] width;
      logic [DIMW-1:0] height;
      logic            eight;
      logic            objval;
   } cfg_type;

   typedef struct packed {
      logic [CNTW-1:0] count;
      logic [SZW-1:0]  best;
      logic [SZW-1:0]  second;
   } res_type;

   // zero used as one, large values capped
   function automatic logic [DIMW-1:0] clamp_dim(input logic [DIMW-1:0] v,
                                                 input logic [DIMW-1:0] maxv);
      logic [DIMW-1:0] r;
      r = v;
      if (v == '0) r = DIMW'(1);
      else if (v > maxv) r = maxv;
      return r;
   endfunction

   // neighbor offsets, even codes are the four direct neighbors
   function automatic logic [1:0] nb_dx(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0, 3'd1, 3'd7: r = 2'b01;
         3'd3, 3'd4, 3'd5: r = 2'b11;
         default:          r = 2'b00;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nb_dy(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd1, 3'd2, 3'd3: r = 2'b11;
         3'd5, 3'd6, 3'd7: r = 2'b01;
         default:          r = 2'b00;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/bbss_fill_core.sv
// ----------------------------------------------------------------------------
// bbss_fill_core
// Frame store, visited map and fill stack with the flood fill sequencer.
// ----------------------------------------------------------------------------
module bbss_fill_core (
   input  logic                      clock,
   input  logic                      reset,
   input  bbss_pkg::cfg_type         cfg,
   input  logic                      load_valid,
   input  logic                      load_pixel,
   input  logic                      load_last,
   input  logic                      out_free,
   output logic                      busy,
   output logic                      res_valid,
   output bbss_pkg::res_type         res
);

   localparam int XW  = bbss_pkg::XW;
   localparam int YW  = bbss_pkg::YW;
   localparam int AW  = bbss_pkg::AW;
   localparam int SPW = bbss_pkg::SPW;
   localparam int SZW = bbss_pkg::SZW;
   localparam int CW  = bbss_pkg::CNTW;
   localparam int DW  = bbss_pkg::DIMW;
   localparam int DEPTH = 1 << AW;

   // linear store address of a pixel, rows packed at the width in use
   function automatic logic [AW-1:0] lin_addr(input logic [YW-1:0] y,
                                              input logic [XW-1:0] x,
                                              input logic [DW-1:0] w);
      logic [SPW-1:0] p;
      p = SPW'(y) * SPW'(w) + SPW'(x);
      return p[AW-1:0];
   endfunction

   bbss_pkg::state_type state_ff, state_in;

   logic [XW-1:0]  sx_ff, sx_in, cx_ff, cx_in;
   logic [YW-1:0]  sy_ff, sy_in, cy_ff, cy_in;
   logic [SPW-1:0] la_ff, la_in;
   logic [2:0]     k_ff, k_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [SZW-1:0] size_ff, size_in, best_ff, best_in, second_ff, second_in;
   logic [CW-1:0]  count_ff, count_in;

   // memory ports
   logic           pix_mem [DEPTH];
   logic           vis_mem [DEPTH];
   logic [AW-1:0]  stk_mem [DEPTH];
   logic           pix_we, pix_wd, vis_we, vis_wd, stk_we;
   logic [AW-1:0]  pix_wa, pix_ra, vis_wa, vis_ra, stk_wa, stk_ra, stk_wd;
   logic           pix_rd_ff, vis_rd_ff;
   logic [AW-1:0]  stk_rd_ff;

   // neighbor position
   logic [1:0]     dxc, dyc;
   logic [DW:0]    nx, ny;
   logic           nb_in, nb_use, hit;
   logic [AW-1:0]  naddr, saddr, nxy, sxy;
   logic [SPW-1:0] npix;
   logic           scan_last, sx_end;

   always_ff @(posedge clock) begin
      if (pix_we) pix_mem[pix_wa] <= pix_wd;
      pix_rd_ff <= pix_mem[pix_ra];
   end

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_rd_ff <= vis_mem[vis_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // neighbor address and bounds
   always_comb begin
      dxc = bbss_pkg::nb_dx(k_ff);
      dyc = bbss_pkg::nb_dy(k_ff);
      nx = {2'b00, cx_ff} + {{DW{dxc[1]}}, dxc[0]};
      ny = {2'b00, cy_ff} + {{DW{dyc[1]}}, dyc[0]};
      nb_in  = !nx[DW] && !ny[DW] && (nx[DW-1:0] < cfg.width) && (ny[DW-1:0] < cfg.height);
      nb_use = nb_in && (cfg.eight || !k_ff[0]);
      nxy    = {ny[YW-1:0], nx[XW-1:0]};
      sxy    = {sy_ff, sx_ff};
      naddr  = lin_addr(ny[YW-1:0], nx[XW-1:0], cfg.width);
      saddr  = lin_addr(sy_ff, sx_ff, cfg.width);
      npix   = SPW'(cfg.width) * SPW'(cfg.height);
      hit    = (pix_rd_ff == cfg.objval) && !vis_rd_ff;
      sx_end = ({1'b0, sx_ff} == cfg.width - DW'(1));
      scan_last = sx_end && ({1'b0, sy_ff} == cfg.height - DW'(1));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      la_in = la_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  cx_in = cx_ff;  cy_in = cy_ff;
      k_in  = k_ff;   sp_in = sp_ff;  size_in = size_ff;
      best_in = best_ff;  second_in = second_ff;  count_in = count_ff;
      pix_we = 1'b0;  pix_wa = la_ff[AW-1:0];  pix_wd = load_pixel;
      vis_we = 1'b0;  vis_wa = saddr;  vis_wd = 1'b0;
      stk_we = 1'b0;  stk_wa = sp_ff[AW-1:0];  stk_wd = sxy;
      pix_ra = saddr; vis_ra = saddr;  stk_ra = sp_ff[AW-1:0] - AW'(1);
      res_valid = 1'b0;
      case (state_ff)
         // loading pixels in raster order, extra pixels dropped
         bbss_pkg::ST_IDLE: begin
            if (load_valid) begin
               if (la_ff < npix) begin
                  pix_we = 1'b1;
                  la_in = la_ff + SPW'(1);
               end
               if (load_last) begin
                  la_in = '0;
                  sx_in = '0;  sy_in = '0;
                  best_in = '0;  second_in = '0;  count_in = '0;
                  state_in = bbss_pkg::ST_CLEAR;
               end
            end
         end
         // visited map sweep
         bbss_pkg::ST_CLEAR: begin
            vis_we = 1'b1;
            if (scan_last) begin
               sx_in = '0;  sy_in = '0;
               state_in = bbss_pkg::ST_SCAN_RD;
            end else if (sx_end) begin
               sx_in = '0;  sy_in = sy_ff + YW'(1);
            end else begin
               sx_in = sx_ff + XW'(1);
            end
         end
         bbss_pkg::ST_SCAN_RD: state_in = bbss_pkg::ST_SCAN_EV;
         // seed check
         bbss_pkg::ST_SCAN_EV: begin
            if (hit) begin
               vis_we = 1'b1;  vis_wd = 1'b1;
               stk_we = 1'b1;  stk_wa = '0;
               sp_in = SPW'(1);  size_in = '0;
               state_in = bbss_pkg::ST_POP;
            end else if (scan_last) begin
               state_in = bbss_pkg::ST_DONE;
            end else begin
               state_in = bbss_pkg::ST_SCAN_RD;
               if (sx_end) begin sx_in = '0; sy_in = sy_ff + YW'(1); end
               else sx_in = sx_ff + XW'(1);
            end
         end
         // pop or finish the object
         bbss_pkg::ST_POP: begin
            if (sp_ff != '0) begin
               sp_in = sp_ff - SPW'(1);
               state_in = bbss_pkg::ST_POP_EV;
            end else begin
               if (count_ff != CW'(bbss_pkg::MAX_OBJECTS)) count_in = count_ff + CW'(1);
               if (size_ff > best_ff) begin
                  second_in = best_ff;  best_in = size_ff;
               end else if (size_ff > second_ff) begin
                  second_in = size_ff;
               end
               if (scan_last) begin
                  state_in = bbss_pkg::ST_DONE;
               end else begin
                  state_in = bbss_pkg::ST_SCAN_RD;
                  if (sx_end) begin sx_in = '0; sy_in = sy_ff + YW'(1); end
                  else sx_in = sx_ff + XW'(1);
               end
            end
         end
         bbss_pkg::ST_POP_EV: begin
            cx_in = stk_rd_ff[XW-1:0];
            cy_in = stk_rd_ff[AW-1:XW];
            size_in = size_ff + SZW'(1);
            k_in = '0;
            state_in = bbss_pkg::ST_NB_RD;
         end
         // neighbor read
         bbss_pkg::ST_NB_RD: begin
            pix_ra = naddr;  vis_ra = naddr;
            if (nb_use) state_in = bbss_pkg::ST_NB_EV;
            else if (k_ff == 3'd7) state_in = bbss_pkg::ST_POP;
            else k_in = k_ff + 3'd1;
         end
         // neighbor mark and push
         bbss_pkg::ST_NB_EV: begin
            if (hit) begin
               vis_we = 1'b1;  vis_wa = naddr;  vis_wd = 1'b1;
               stk_we = 1'b1;  stk_wd = nxy;
               sp_in = sp_ff + SPW'(1);
            end
            if (k_ff == 3'd7) state_in = bbss_pkg::ST_POP;
            else begin
               k_in = k_ff + 3'd1;
               state_in = bbss_pkg::ST_NB_RD;
            end
         end
         bbss_pkg::ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in = bbss_pkg::ST_IDLE;
            end
         end
         default: state_in = bbss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bbss_pkg::ST_IDLE;
         la_ff <= '0;
         sp_ff <= '0;  size_ff <= '0;
         best_ff <= '0;  second_ff <= '0;  count_ff <= '0;
      end else begin
         state_ff <= state_in;
         la_ff <= la_in;
         sp_ff <= sp_in;  size_ff <= size_in;
         best_ff <= best_in;  second_ff <= second_in;  count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;  sy_ff <= sy_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;
      k_ff  <= k_in;
   end

   assign busy = (state_ff != bbss_pkg::ST_IDLE);
   assign res  = '{count: count_ff, best: best_ff, second: second_ff};

   // stack never holds more entries than the largest frame has pixels
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= bbss_pkg::AREA) else $error("fill stack overflow");

   // the largest size never falls below the runner-up
   a_order: assert property (@(posedge clock) disable iff (reset)
      best_ff >= second_ff) else $error("size order broken");

   // a result is only given after the scan finished
   a_res: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> $past(state_ff) == bbss_pkg::ST_DONE || state_ff == bbss_pkg::ST_DONE)
      else $error("result outside done state");

endmodule

FILE: hw/rtl/binary_blob_size_selector.sv
// ----------------------------------------------------------------------------
// binary_blob_size_selector
// Counts connected objects in a binary frame and reports the two largest.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry one pixel each in raster order; frame_end marks the last
//   pixel. Pixels are taken one per cycle while the block is loading.
//   After frame_end the block stalls requests while it clears the visited
//   map and scans the frame: each pixel is read and checked as a seed, each
//   object pixel is popped from the fill stack and its neighbors are read
//   and checked, or skipped when outside the frame or, without eight
//   neighbors, diagonal. The fill is bounded by the single read port of the
//   visited and pixel stores.
//   One response per frame carries the object count, largest and second
//   size and the kept count; it sits in an output register until taken.
//   The next frame can load while a response waits; a new response waits
//   for the previous one to leave. Reset clears control state and restores
//   the register defaults; the frame store holds nothing valid until loaded.
//   csr writes must only come while no frame is in flight.
// ----------------------------------------------------------------------------
module binary_blob_size_selector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pixel_value,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_object_count,
   output logic [16:0] rsp_largest_size,
   output logic [16:0] rsp_second_size,
   output logic [1:0]  rsp_kept_objects,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int DW = bbss_pkg::DIMW;

   logic [DW-1:0] width_ff, height_ff;
   logic          eight_ff, objval_ff;
   logic [15:0]   ratio_ff;

   logic              rsp_valid_ff;
   bbss_pkg::res_type rsp_res_ff;
   logic [1:0]        kept_ff, kept_in;

   bbss_pkg::cfg_type cfg;
   bbss_pkg::res_type core_res;
   logic              core_busy, core_res_valid;
   logic [32:0]       lhs, rhs;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(256);
         height_ff <= DW'(256);
         eight_ff  <= 1'b1;
         objval_ff <= 1'b1;
         ratio_ff  <= 16'd3840;
      end else if (csr_write_enable) begin
         case (csr_index)
            bbss_pkg::REG_WIDTH:  width_ff  <= csr_write_data[DW-1:0];
            bbss_pkg::REG_HEIGHT: height_ff <= csr_write_data[DW-1:0];
            bbss_pkg::REG_EIGHT:  eight_ff  <= csr_write_data[0];
            bbss_pkg::REG_OBJVAL: objval_ff <= csr_write_data[0];
            bbss_pkg::REG_RATIO:  ratio_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.width  = bbss_pkg::clamp_dim(width_ff,  DW'(bbss_pkg::MAX_WIDTH));
      cfg.height = bbss_pkg::clamp_dim(height_ff, DW'(bbss_pkg::MAX_HEIGHT));
      cfg.eight  = eight_ff;
      cfg.objval = objval_ff;
   end

   bbss_fill_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load_valid (req_valid && !req_stall),
      .load_pixel (req_pixel_value),
      .load_last  (req_frame_end),
      .out_free   (!rsp_valid_ff),
      .busy       (core_busy),
      .res_valid  (core_res_valid),
      .res        (core_res)
   );

   assign req_stall = core_busy;

   // kept count from the ratio test
   always_comb begin
      lhs = 33'(core_res.second) * 33'(ratio_ff);
      rhs = 33'({core_res.best, 8'd0});
      if (core_res.best == '0) kept_in = 2'd0;
      else if (core_res.second == '0) kept_in = 2'd1;
      else if (lhs <= rhs) kept_in = 2'd1;
      else kept_in = 2'd2;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (core_res_valid) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (core_res_valid) begin
         rsp_res_ff <= core_res;
         kept_ff    <= kept_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_object_count = rsp_res_ff.count;
   assign rsp_largest_size = rsp_res_ff.best;
   assign rsp_second_size  = rsp_res_ff.second;
   assign rsp_kept_objects = kept_ff;

endmodule
